FILE: rtl/sgm_pkg.sv
package sgm_pkg;

  localparam int unsigned PixelW  = 8;
  localparam int unsigned OutRowW = 12;
  localparam int unsigned OutColW = 10;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 13;
  localparam int unsigned WidthW  = 11;
  localparam int unsigned HeightW = 13;
  localparam int unsigned GradW   = 12;
  localparam int unsigned SqW     = 21;
  localparam int unsigned SumW    = 22;
  localparam int unsigned RootW   = 8;

  localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = CfgIdxW'(1);

  localparam logic [WidthW-1:0]  WIDTH_RESET  = WidthW'(1024);
  localparam logic [HeightW-1:0] HEIGHT_RESET = HeightW'(4096);

  typedef struct packed {
    logic [PixelW-1:0] pixel_value;
  } pixel_beat_t;

  typedef struct packed {
    logic [PixelW-1:0]  magnitude;
    logic [OutRowW-1:0] out_row;
    logic [OutColW-1:0] out_col;
    logic               last_of_run;
    logic               end_of_frame;
  } result_beat_t;

  // Bit 1 selects the row below, bit 0 the column to the right.
  typedef enum logic [1:0] {
    JOB_BASE   = 2'b00,
    JOB_RIGHT  = 2'b01,
    JOB_BELOW  = 2'b10,
    JOB_CORNER = 2'b11
  } job_e;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_GRAD = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_SUM  = 7'b0010000,
    S_ROOT = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic            start;
    logic [SumW-1:0] value;
  } root_req_t;

  typedef struct packed {
    logic             done;
    logic [RootW-1:0] root;
  } root_rsp_t;

endpackage

FILE: rtl/sgm_stream_if.sv
interface sgm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/sgm_isqrt.sv
module sgm_isqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sgm_pkg::root_req_t req_i,
  output sgm_pkg::root_rsp_t rsp_o
);

  localparam int unsigned RemW = 16;

  logic            busy_q;
  logic            done_q;
  logic [RemW-1:0] rem_q;
  logic [RemW:0]   res_q;
  logic [RemW-1:0] bit_q;
  logic [RemW:0]   trial;

  assign trial = res_q + {1'b0, bit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        // Anything at or above 2^16 saturates and needs no iterations.
        busy_q <= ~|req_i.value[sgm_pkg::SumW-1:RemW];
        done_q <= |req_i.value[sgm_pkg::SumW-1:RemW];
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.value[RemW-1:0];
      res_q <= |req_i.value[sgm_pkg::SumW-1:RemW] ? (RemW+1)'(255) : '0;
      bit_q <= RemW'(1) << (RemW - 2);
    end else if (busy_q) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_q <= rem_q - trial[RemW-1:0];
        res_q <= (res_q >> 1) + {1'b0, bit_q};
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = res_q[sgm_pkg::RootW-1:0];

endmodule

FILE: rtl/sobel_gradient_magnitude_core.sv
// Sobel 3x3 gradient magnitude over a row-major 8-bit frame. Each accepted pixel
// reads one entry of a single line memory that holds the two rows above it,
// writes the entry back and shifts the 3x3 window; no new pixel is taken until
// every result it causes has been delivered. Each result passes through the
// gradient, squaring, sum, an iterative square root of one bit pair per cycle
// (8 steps, none when saturated) and the output beat. A pixel causes up to four
// results. Output pixel (r, c) appears with input pixel (r+1, c+1); border
// pixels of the last row and column appear with their neighbors. A write to the
// width or height register restarts the frame at (0, 0), unless it falls in the
// read state, where the pixel's position update wins. Width and height below 2
// act as 2, above the parameter maxima they act as the maxima.
module sobel_gradient_magnitude_core #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sgm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sgm_pkg::CfgW-1:0]     cfg_data_i,
  sgm_stream_if.sink                   pixel_i,
  sgm_stream_if.source                 result_o
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned RowW = $clog2(MAX_HEIGHT);
  localparam int unsigned PW   = sgm_pkg::PixelW;
  localparam int unsigned GW   = sgm_pkg::GradW;

  sgm_pkg::state_e  state_q;
  sgm_pkg::job_e    job_q, job_next;
  logic             has_next;

  logic [sgm_pkg::WidthW-1:0]  width_q;
  logic [sgm_pkg::HeightW-1:0] height_q;
  logic [ColW-1:0]             col_q, col_cur_q, last_col_idx;
  logic [RowW-1:0]             row_q, row_cur_q, last_row_idx;
  logic [31:0]                 w_ext, h_ext, w_eff, h_eff;

  logic                        at_last_col, at_last_row;
  logic                        last_col_q, last_row_q, col_is1_q, row_is1_q;

  logic [PW-1:0]               pix_q;
  logic [2*PW-1:0]             line_mem [MAX_WIDTH];
  logic [2*PW-1:0]             rd_q;
  logic [PW-1:0]               win_q [3][3];

  logic signed [GW-1:0]        gx_q, gy_q, gx_d, gy_d;
  logic signed [2*GW-1:0]      prod_x, prod_y;
  logic [sgm_pkg::SqW-1:0]     sqx_q, sqy_q;

  sgm_pkg::root_req_t          root_req;
  sgm_pkg::root_rsp_t          root_rsp;
  sgm_pkg::result_beat_t       res_q;

  // Effective frame size.
  always_comb begin
    w_ext = 32'(width_q);
    h_ext = 32'(height_q);
    if (w_ext < 32'd2) begin
      w_eff = 32'd2;
    end else if (w_ext > MAX_WIDTH) begin
      w_eff = MAX_WIDTH;
    end else begin
      w_eff = w_ext;
    end
    if (h_ext < 32'd2) begin
      h_eff = 32'd2;
    end else if (h_ext > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else begin
      h_eff = h_ext;
    end
  end

  assign last_col_idx = ColW'(w_eff - 32'd1);
  assign last_row_idx = RowW'(h_eff - 32'd1);
  assign at_last_col  = (col_q == last_col_idx);
  assign at_last_row  = (row_q == last_row_idx);

  // Order of results for one pixel: base, below, right, corner.
  always_comb begin
    job_next = sgm_pkg::JOB_BASE;
    has_next = 1'b0;
    unique case (job_q)
      sgm_pkg::JOB_BASE: begin
        if (last_row_q) begin
          job_next = sgm_pkg::JOB_BELOW;
          has_next = 1'b1;
        end else if (last_col_q) begin
          job_next = sgm_pkg::JOB_RIGHT;
          has_next = 1'b1;
        end
      end
      sgm_pkg::JOB_BELOW: begin
        if (last_col_q) begin
          job_next = sgm_pkg::JOB_RIGHT;
          has_next = 1'b1;
        end
      end
      sgm_pkg::JOB_RIGHT: begin
        if (last_row_q) begin
          job_next = sgm_pkg::JOB_CORNER;
          has_next = 1'b1;
        end
      end
      default: begin
        job_next = sgm_pkg::JOB_BASE;
        has_next = 1'b0;
      end
    endcase
  end

  // Window taps for the current result. Rows below the frame reuse the last
  // row, and rows or columns above or left of it mirror onto index one.
  always_comb begin
    logic [PW-1:0] pt [3];
    logic [PW-1:0] pm [3];
    logic [PW-1:0] pb [3];
    logic [PW-1:0] tl, tc, tr, ml, mr, bl, bc, br;
    for (int k = 0; k < 3; k++) begin
      pt[k] = job_q[1] ? win_q[k][1] : (row_is1_q ? win_q[k][2] : win_q[k][0]);
      pm[k] = job_q[1] ? win_q[k][2] : win_q[k][1];
      pb[k] = win_q[k][2];
    end
    tl = job_q[0] ? pt[1] : (col_is1_q ? pt[2] : pt[0]);
    ml = job_q[0] ? pm[1] : (col_is1_q ? pm[2] : pm[0]);
    bl = job_q[0] ? pb[1] : (col_is1_q ? pb[2] : pb[0]);
    tc = job_q[0] ? pt[2] : pt[1];
    bc = job_q[0] ? pb[2] : pb[1];
    tr = pt[2];
    mr = pm[2];
    br = pb[2];
    gx_d = (GW'(bl) + (GW'(bc) << 1) + GW'(br)) - (GW'(tl) + (GW'(tc) << 1) + GW'(tr));
    gy_d = (GW'(tr) + (GW'(mr) << 1) + GW'(br)) - (GW'(tl) + (GW'(ml) << 1) + GW'(bl));
  end

  assign prod_x = gx_q * gx_q;
  assign prod_y = gy_q * gy_q;

  assign root_req.start = (state_q == sgm_pkg::S_SUM);
  assign root_req.value = sgm_pkg::SumW'(sqx_q) + sgm_pkg::SumW'(sqy_q);

  sgm_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (root_req),
    .rsp_o  (root_rsp)
  );

  // Line memory: each entry holds {row two above, row above} for one column.
  always_ff @(posedge clk_i) begin
    if (state_q == sgm_pkg::S_IDLE) begin
      rd_q <= line_mem[col_q];
    end
    if (state_q == sgm_pkg::S_READ) begin
      line_mem[col_q] <= {rd_q[PW-1:0], pix_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sgm_pkg::S_IDLE;
      job_q    <= sgm_pkg::JOB_BASE;
      width_q  <= sgm_pkg::WIDTH_RESET;
      height_q <= sgm_pkg::HEIGHT_RESET;
      col_q    <= '0;
      row_q    <= '0;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[k][j] <= '0;
        end
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sgm_pkg::REG_IMAGE_WIDTH: begin
            width_q <= cfg_data_i[sgm_pkg::WidthW-1:0];
            col_q   <= '0;
            row_q   <= '0;
          end
          sgm_pkg::REG_IMAGE_HEIGHT: begin
            height_q <= cfg_data_i[sgm_pkg::HeightW-1:0];
            col_q    <= '0;
            row_q    <= '0;
          end
          default: begin
          end
        endcase
      end
      unique case (state_q)
        sgm_pkg::S_IDLE: begin
          if (pixel_i.valid) begin
            state_q <= sgm_pkg::S_READ;
          end
        end
        sgm_pkg::S_READ: begin
          for (int k = 0; k < 2; k++) begin
            for (int j = 0; j < 3; j++) begin
              win_q[k][j] <= win_q[k+1][j];
            end
          end
          win_q[2][0] <= rd_q[2*PW-1:PW];
          win_q[2][1] <= rd_q[PW-1:0];
          win_q[2][2] <= pix_q;
          job_q <= sgm_pkg::JOB_BASE;
          if (at_last_col) begin
            col_q <= '0;
            row_q <= at_last_row ? '0 : row_q + 1'b1;
          end else begin
            col_q <= col_q + 1'b1;
          end
          if ((row_q != '0) && (col_q != '0)) begin
            state_q <= sgm_pkg::S_GRAD;
          end else begin
            state_q <= sgm_pkg::S_IDLE;
          end
        end
        sgm_pkg::S_GRAD: state_q <= sgm_pkg::S_MUL;
        sgm_pkg::S_MUL:  state_q <= sgm_pkg::S_SUM;
        sgm_pkg::S_SUM:  state_q <= sgm_pkg::S_ROOT;
        sgm_pkg::S_ROOT: begin
          if (root_rsp.done) begin
            state_q <= sgm_pkg::S_OUT;
          end
        end
        sgm_pkg::S_OUT: begin
          if (result_o.ready) begin
            if (has_next) begin
              job_q   <= job_next;
              state_q <= sgm_pkg::S_GRAD;
            end else begin
              state_q <= sgm_pkg::S_IDLE;
            end
          end
        end
        default: state_q <= sgm_pkg::S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == sgm_pkg::S_IDLE && pixel_i.valid) begin
      pix_q <= pixel_i.data.pixel_value;
    end
    if (state_q == sgm_pkg::S_READ) begin
      col_cur_q  <= col_q;
      row_cur_q  <= row_q;
      last_col_q <= at_last_col;
      last_row_q <= at_last_row;
      col_is1_q  <= (col_q == ColW'(1));
      row_is1_q  <= (row_q == RowW'(1));
    end
    if (state_q == sgm_pkg::S_GRAD) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
    end
    if (state_q == sgm_pkg::S_MUL) begin
      sqx_q <= sgm_pkg::SqW'(prod_x);
      sqy_q <= sgm_pkg::SqW'(prod_y);
    end
    if (state_q == sgm_pkg::S_ROOT && root_rsp.done) begin
      res_q.magnitude    <= root_rsp.root;
      res_q.out_row      <= sgm_pkg::OutRowW'(job_q[1] ? row_cur_q : row_cur_q - 1'b1);
      res_q.out_col      <= sgm_pkg::OutColW'(job_q[0] ? col_cur_q : col_cur_q - 1'b1);
      res_q.last_of_run  <= ~has_next;
      res_q.end_of_frame <= (job_q == sgm_pkg::JOB_CORNER);
    end
  end

  assign pixel_i.ready  = (state_q == sgm_pkg::S_IDLE);
  assign result_o.valid = (state_q == sgm_pkg::S_OUT);
  assign result_o.data  = res_q;

endmodule
